// ===== design/sbpr_pkg.sv =====
// Package for the servo bus packet receiver.
// Holds protocol constants, status codes and the parser result type; no dependencies.
package sbpr_pkg;

    localparam int MAX_PARAMS = 128;
    localparam int POS_WIDTH  = $clog2(MAX_PARAMS + 1);

    localparam logic [7:0] HDR_BYTE = 8'hFF;
    localparam logic [7:0] MIN_LEN  = 8'd2;

    typedef enum logic [2:0] {
        ST_NONE    = 3'd0,
        ST_PARAM   = 3'd1,
        ST_GOOD    = 3'd2,
        ST_BAD_SUM = 3'd3,
        ST_LEN_ERR = 3'd4
    } status_t;

    typedef enum logic [5:0] {
        PH_HUNT0 = 6'b000001,
        PH_HUNT1 = 6'b000010,
        PH_ID    = 6'b000100,
        PH_LEN   = 6'b001000,
        PH_INSTR = 6'b010000,
        PH_PARAM = 6'b100000
    } phase_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] packet_id;
        logic [7:0] instruction_code;
        logic [6:0] param_index;
        logic [7:0] param_value;
        logic [7:0] param_count;
    } result_t;

endpackage

// ===== design/sbpr_parser.sv =====
// Packet parse state for the servo bus receiver: header hunt, id, length,
// instruction, parameters and checksum. Depends on sbpr_pkg.
module sbpr_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic [7:0]         byte_in,
    output sbpr_pkg::result_t  result
);

    sbpr_pkg::phase_t                 phase_reg, phase_next;
    logic [sbpr_pkg::POS_WIDTH-1:0]   pos_reg, pos_next;
    logic [7:0]                       id_reg, id_next;
    logic [7:0]                       instr_reg, instr_next;
    logic [7:0]                       count_reg, count_next;
    logic [7:0]                       sum_reg, sum_next;

    logic [8:0]                       len_minus;
    logic                             len_bad;
    logic [7:0]                       sum_add;
    sbpr_pkg::status_t                status;
    logic [6:0]                       index_out;
    logic [7:0]                       value_out;

    assign len_minus = {1'b0, byte_in} - {1'b0, sbpr_pkg::MIN_LEN};
    assign len_bad   = (byte_in < sbpr_pkg::MIN_LEN)
                    || (len_minus > 9'(sbpr_pkg::MAX_PARAMS));
    assign sum_add   = sum_reg + byte_in;

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        id_next    = id_reg;
        instr_next = instr_reg;
        count_next = count_reg;
        sum_next   = sum_reg;
        status     = sbpr_pkg::ST_NONE;
        index_out  = '0;
        value_out  = '0;
        case (phase_reg)
            sbpr_pkg::PH_HUNT0:
            begin
                if (byte_in == sbpr_pkg::HDR_BYTE)
                begin
                    phase_next = sbpr_pkg::PH_HUNT1;
                end
            end
            sbpr_pkg::PH_HUNT1:
            begin
                if (byte_in == sbpr_pkg::HDR_BYTE)
                begin
                    id_next    = '0;
                    instr_next = '0;
                    count_next = '0;
                    sum_next   = '0;
                    phase_next = sbpr_pkg::PH_ID;
                end
                else
                begin
                    phase_next = sbpr_pkg::PH_HUNT0;
                end
            end
            sbpr_pkg::PH_ID:
            begin
                id_next    = byte_in;
                sum_next   = sum_add;
                phase_next = sbpr_pkg::PH_LEN;
            end
            sbpr_pkg::PH_LEN:
            begin
                if (len_bad)
                begin
                    status     = sbpr_pkg::ST_LEN_ERR;
                    count_next = '0;
                    phase_next = sbpr_pkg::PH_HUNT0;
                end
                else
                begin
                    count_next = len_minus[7:0];
                    sum_next   = sum_add;
                    phase_next = sbpr_pkg::PH_INSTR;
                end
            end
            sbpr_pkg::PH_INSTR:
            begin
                instr_next = byte_in;
                sum_next   = sum_add;
                pos_next   = '0;
                phase_next = sbpr_pkg::PH_PARAM;
            end
            sbpr_pkg::PH_PARAM:
            begin
                if (8'(pos_reg) < count_reg)
                begin
                    status    = sbpr_pkg::ST_PARAM;
                    index_out = 7'(pos_reg);
                    value_out = byte_in;
                    sum_next  = sum_add;
                    pos_next  = pos_reg + 1'b1;
                end
                else
                begin
                    status     = (~sum_reg == byte_in) ? sbpr_pkg::ST_GOOD
                                                       : sbpr_pkg::ST_BAD_SUM;
                    phase_next = sbpr_pkg::PH_HUNT0;
                end
            end
            default:
            begin
                phase_next = sbpr_pkg::PH_HUNT0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= sbpr_pkg::PH_HUNT0;
            pos_reg   <= '0;
            id_reg    <= '0;
            instr_reg <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            id_reg    <= id_next;
            instr_reg <= instr_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    assign result.status           = status;
    assign result.packet_id        = id_next;
    assign result.instruction_code = instr_next;
    assign result.param_index      = index_out;
    assign result.param_value      = value_out;
    assign result.param_count      = count_next;

endmodule

// ===== design/servo_bus_packet_receiver.sv =====
// Servo bus packet receiver top level: parser plus registered output item.
// The result item of an accepted byte is registered onto m_tdata/m_tuser in the cycle after it.
// Throughput: one byte per cycle; s_tready drops only while the output item stalls.
// Reset (rst_n, async, active low): header hunt, held id/instruction/count/sum zero,
// no output item pending. Depends on sbpr_pkg and sbpr_parser.
module servo_bus_packet_receiver (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [7:0] packet_id, [15:8] instruction_code,
                                   // [22:16] param_index, [30:23] param_value,
                                   // [38:31] param_count, [39] zero
    output logic [2:0]  m_tuser    // [2:0] status
);

    sbpr_pkg::result_t  result;
    sbpr_pkg::result_t  out_reg;
    logic               out_valid_reg;
    logic               accept;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    sbpr_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .byte_in (s_tdata),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            out_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {1'b0, out_reg.param_count, out_reg.param_value,
                       out_reg.param_index, out_reg.instruction_code,
                       out_reg.packet_id};

    // A parameter item always lies inside the declared count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == sbpr_pkg::ST_PARAM))
            |-> (8'(m_tdata[22:16]) < m_tdata[38:31]))
        else $error("parameter index beyond declared count");

    // A length error clears the declared count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == sbpr_pkg::ST_LEN_ERR)) |-> (m_tdata[38:31] == 8'd0))
        else $error("length error with nonzero count");

    // Input stalls only behind a pending, unaccepted output item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (out_valid_reg && !m_tready))
        else $error("input stalled without output backpressure");

    // An accepted byte always yields an output item next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> m_tvalid)
        else $error("accepted byte produced no item");

endmodule
